// ===== rtl/dpx_filled_sample_unpacker_assert.svh =====
// ----------------------------------------------------------------------------
// dpx_filled_sample_unpacker_assert.svh
// Assertion macros used by the sample unpacker checker.
// ----------------------------------------------------------------------------
`ifndef DPX_FILLED_SAMPLE_UNPACKER_ASSERT_SVH
`define DPX_FILLED_SAMPLE_UNPACKER_ASSERT_SVH

// Check that a stalled transaction keeps its valid and payload
`define DPX_ASSERT_HOLD(label, vld, stl, sig) \
  label: assert property (@(posedge clk) disable iff (rst) \
    ((vld) && (stl)) |=> ((vld) && $stable(sig))) \
    else $error("stalled transaction changed");

// Check a same-cycle implication
`define DPX_ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (pre) |-> (post)) else $error("implication failed");

// Check an implication in the following cycle
`define DPX_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (pre) |=> (post)) else $error("next-cycle implication failed");

`endif

// ===== rtl/dpx_pkg.sv =====
// ----------------------------------------------------------------------------
// dpx_pkg
// Types and constants shared by the filled sample unpacker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dpx_pkg;

  // Component rotation
  localparam int COMPONENTS = 3;
  localparam int COMP_W     = 2;

  // Sample and word widths
  localparam int WORD_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int MAX_SAMP = 4;
  localparam int IDX_W    = 2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Configuration register indexes
  localparam logic CFG_BYTE_ORDER  = 1'b0;
  localparam logic CFG_SAMPLE_BITS = 1'b1;

  // Sample size codes
  typedef enum logic [1:0] {
    MODE_8  = 2'd0,
    MODE_10 = 2'd1,
    MODE_12 = 2'd2,
    MODE_16 = 2'd3
  } sample_mode_t;

  // One classified word: its samples, index of final sample, frame end flag
  typedef struct packed {
    logic [MAX_SAMP-1:0][SAMPLE_W-1:0] samples;
    logic [IDX_W-1:0]                  last_idx;
    logic                              frame_end;
  } entry_t;

  // Queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Component index that follows c
  function automatic logic [COMP_W-1:0] next_comp(input logic [COMP_W-1:0] c);
    logic [COMP_W:0] inc;
    inc = {1'b0, c} + (COMP_W+1)'(1);
    if (inc >= (COMP_W+1)'(COMPONENTS)) begin
      return '0;
    end
    return inc[COMP_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dpx_queue.sv =====
// ----------------------------------------------------------------------------
// dpx_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dpx_queue import dpx_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t wr_entry,
  input  wire logic   pop,
  output entry_t      rd_entry,
  output q_stat_t     stat
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  // Write the slot at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign rd_entry   = slots[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

// ===== rtl/dpx_front.sv =====
// ----------------------------------------------------------------------------
// dpx_front
// Holds configuration, accepts data words and splits them into samples.
// ----------------------------------------------------------------------------
`default_nettype none

module dpx_front import dpx_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_index,
  input  wire logic [1:0]        cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WORD_W-1:0] data_word,
  input  wire logic              last_word,
  input  wire q_stat_t           stat,
  output logic                   push,
  output entry_t                 wr_entry
);

  logic         byte_order;
  sample_mode_t mode;
  logic [7:0]   b0, b1, b2, b3;
  logic [WORD_W-1:0] w;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order <= 1'b0;
      mode       <= MODE_10;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BYTE_ORDER:  byte_order <= cfg_data[0];
        CFG_SAMPLE_BITS: mode       <= sample_mode_t'(cfg_data);
        default:         ;
      endcase
    end
  end

  // Accept a word whenever the queue has room
  assign in_stall = stat.full;
  assign push     = in_valid && !stat.full;

  // Assemble the word in file byte order
  assign b0 = data_word[7:0];
  assign b1 = data_word[15:8];
  assign b2 = data_word[23:16];
  assign b3 = data_word[31:24];
  assign w  = byte_order ? data_word : {b0, b1, b2, b3};

  // Split into samples by size
  always_comb begin
    wr_entry           = '0;
    wr_entry.frame_end = last_word;
    unique case (mode)
      MODE_8: begin
        wr_entry.samples[0] = {8'h00, b0};
        wr_entry.samples[1] = {8'h00, b1};
        wr_entry.samples[2] = {8'h00, b2};
        wr_entry.samples[3] = {8'h00, b3};
        wr_entry.last_idx   = IDX_W'(3);
      end
      MODE_10: begin
        wr_entry.samples[0] = {6'h00, w[31:22]};
        wr_entry.samples[1] = {6'h00, w[21:12]};
        wr_entry.samples[2] = {6'h00, w[11:2]};
        wr_entry.last_idx   = IDX_W'(2);
      end
      MODE_12: begin
        wr_entry.samples[0] = {4'h0, w[31:20]};
        wr_entry.samples[1] = {4'h0, w[15:4]};
        wr_entry.last_idx   = IDX_W'(1);
      end
      MODE_16: begin
        wr_entry.samples[0] = byte_order ? w[15:0] : w[31:16];
        wr_entry.samples[1] = byte_order ? w[31:16] : w[15:0];
        wr_entry.last_idx   = IDX_W'(1);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/dpx_back.sv =====
// ----------------------------------------------------------------------------
// dpx_back
// Emits queued samples one per cycle, unless the output is stalled, with their component index.
// ----------------------------------------------------------------------------
`default_nettype none

module dpx_back import dpx_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire entry_t        rd_entry,
  input  wire q_stat_t       stat,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [SAMPLE_W-1:0] sample,
  output logic [COMP_W-1:0]  component,
  output logic               last
);

  logic [IDX_W-1:0]  idx;
  logic [COMP_W-1:0] comp_cnt;
  logic              can_load;
  logic              emit;
  logic              final_samp;

  assign can_load   = !out_valid || !out_stall;
  assign emit       = can_load && !stat.empty;
  assign final_samp = (idx == rd_entry.last_idx);
  assign pop        = emit && final_samp;

  // Advance sample index and component rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      comp_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (can_load) begin
        out_valid <= emit;
      end
      if (emit) begin
        idx <= final_samp ? '0 : idx + IDX_W'(1);
        if (final_samp && rd_entry.frame_end) begin
          comp_cnt <= '0;
        end else begin
          comp_cnt <= next_comp(comp_cnt);
        end
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (emit) begin
      sample    <= rd_entry.samples[idx];
      component <= comp_cnt;
      last      <= final_samp && rd_entry.frame_end;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dpx_filled_sample_unpacker.sv =====
// ----------------------------------------------------------------------------
// dpx_filled_sample_unpacker
// Unpacks filled DPX data words into R/G/B tagged samples.
// ----------------------------------------------------------------------------
// Each accepted 32-bit word yields four 8-bit, three 10-bit, two 12-bit or
// two 16-bit samples, delivered one per cycle while the output is not
// stalled, from a single output register. The front end takes a word in
// the cycle it arrives while a two-entry queue has room, so input and
// output stall independently; the first sample of a word passes through
// the queue slot and then the output register. Configuration is sampled
// per word and must only be written while the block is idle.
`default_nettype none

module dpx_filled_sample_unpacker import dpx_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [1:0]          cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [WORD_W-1:0]   data_word,
  input  wire logic                last_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [SAMPLE_W-1:0]      sample,
  output logic [COMP_W-1:0]        component,
  output logic                     last
);

  q_stat_t stat;
  entry_t  wr_entry;
  entry_t  rd_entry;
  logic    push;
  logic    pop;

  dpx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_word (data_word),
    .last_word (last_word),
    .stat      (stat),
    .push      (push),
    .wr_entry  (wr_entry)
  );

  dpx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .stat     (stat)
  );

  dpx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rd_entry  (rd_entry),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .component (component),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== rtl/dpx_checker.sv =====
// ----------------------------------------------------------------------------
// dpx_checker
// Port-level checks of the sample unpacker output stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dpx_filled_sample_unpacker_assert.svh"

module dpx_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] sample,
  input wire logic [1:0]  component,
  input wire logic        last
);

  logic out_take;
  logic red_take;

  // Output transaction taken, and a red sample taken inside a frame
  assign out_take = out_valid && !out_stall;
  assign red_take = out_take && !last && (component == 2'd0);

  // Hold a stalled output transaction
  `DPX_ASSERT_HOLD(a_out_hold, out_valid, out_stall, {sample, component, last})

  // Keep the component index within red, green, blue
  `DPX_ASSERT_IMPLY(a_comp_range, out_valid, component != 2'd3)

  // Restart the rotation after a frame's final sample
  `DPX_ASSERT_NEXT(a_frame_restart, out_take && last, !out_valid || component == 2'd0)

  // Advance red to green within a frame
  `DPX_ASSERT_NEXT(a_red_green, red_take, !out_valid || component == 2'd1)

endmodule

bind dpx_filled_sample_unpacker dpx_checker u_dpx_checker (.*);

`default_nettype wire
